// ===== sv/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    // Default sizes of the table
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths of the command and response transfers
    localparam int OPCODE_W  = 2;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int ENTRIES_W = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_REMOVED  = 3'd1,
        STAT_HIT      = 3'd2,
        STAT_MISS     = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_USED  = 2'd1,
        MARK_TOMB  = 2'd2
    } mark_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_REDUCE,
        ST_ISSUE,
        ST_PROBE
    } state_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] found_value;
        logic [ENTRIES_W-1:0]      entries_in_use;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// With a power-of-two CAPACITY the done strobe follows the ISSUE state and k probes, k being
// the number of slots probed (1..CAPACITY, one slot per cycle through the registered
// mark/data memory read); other capacities first pass HASH and REDUCE for key reduction.
// A refused insert or an unused opcode answers in the next cycle without raising busy.
// A new command is taken only in idle, so a probed command must finish first; an immediate answer stays idle.
// Reset clears control state, then sweeps every slot of the mark memory to empty with busy high.
module linear_probe_hash_table_unit #(
    parameter int CAPACITY    = lpht_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH   = lpht_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = lpht_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lpht_pkg::cmd_t cmd,
    output logic               done,
    output lpht_pkg::rsp_t     rsp
);
    import lpht_pkg::*;

    localparam int IW        = $clog2(CAPACITY);
    localparam int KW        = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int VW        = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int HALF      = CAPACITY / 2;
    localparam int CW        = $clog2(HALF + 1);
    localparam bit CAP_POW2  = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [IW-1:0]  LAST_SLOT = IW'(CAPACITY - 1);
    localparam logic [CW-1:0]  HALF_CNT  = CW'(HALF);
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KW) - 64'd1);
    localparam logic [KEY_W-1:0] CAP_KEY  = KEY_W'(CAPACITY);
    localparam logic [KEY_W-1:0] RECIP    = KEY_W'((64'd1 << KEY_W) / 64'(CAPACITY));

    // Slot stores: marks are swept at reset, keys and values are not
    mark_t              mark_mem [CAPACITY];
    logic [KW+VW-1:0]   data_mem [CAPACITY];

    state_t             state_reg, state_next;
    logic [IW-1:0]      slot_reg, slot_next;
    logic [IW-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [CW-1:0]      live_reg, live_next;
    logic               done_reg, done_next;
    rsp_t               rsp_reg, rsp_next;

    opcode_t            op_reg;
    logic [KW-1:0]      key_reg;
    logic [VW-1:0]      val_reg;
    logic [KEY_W-1:0]   quot_reg, quot_next;

    mark_t              mark_rd_reg;
    logic [KW+VW-1:0]   data_rd_reg;

    logic [IW-1:0]      rd_addr;
    logic               mark_we;
    mark_t              mark_wdata;
    logic               data_we;
    logic               load;
    logic [KEY_W-1:0]   key_m;
    logic [KEY_W-1:0]   key_ext;
    logic [IW-1:0]      slot_inc;
    logic [KW-1:0]      rd_key;
    logic [VW-1:0]      rd_val;
    logic               key_match;
    logic               exhausted;

    assign key_m     = cmd.key & KEY_MASK;
    assign key_ext   = KEY_W'(key_reg);
    assign load      = start && (state_reg == ST_IDLE);
    assign slot_inc  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign rd_key    = data_rd_reg[KW+VW-1:VW];
    assign rd_val    = data_rd_reg[VW-1:0];
    assign key_match = (mark_rd_reg == MARK_USED) && (rd_key == key_reg);
    assign exhausted = (probe_cnt_reg == LAST_SLOT);

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            slot_reg      <= '0;
            probe_cnt_reg <= '0;
            live_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            probe_cnt_reg <= probe_cnt_next;
            live_reg      <= live_next;
            done_reg      <= done_next;
        end
    end

    // Capture the command and hold the response
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= cmd.opcode;
            key_reg <= key_m[KW-1:0];
            val_reg <= cmd.value[VW-1:0];
        end
        quot_reg <= quot_next;
        rsp_reg  <= rsp_next;
    end

    // Memory ports: one write and one registered read per store
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[slot_reg] <= mark_wdata;
        end
        mark_rd_reg <= mark_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[slot_reg] <= {key_reg, val_reg};
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    // Next state, probe decisions and response
    always_comb
    begin
        logic [2*KEY_W-1:0] prod;
        logic [KEY_W-1:0]   rem;
        logic               emit;
        logic               hit;
        status_t            stat;

        state_next      = state_reg;
        slot_next       = slot_reg;
        probe_cnt_next  = probe_cnt_reg;
        live_next       = live_reg;
        quot_next       = quot_reg;
        rd_addr         = slot_reg;
        mark_we         = 1'b0;
        mark_wdata      = MARK_EMPTY;
        data_we         = 1'b0;
        emit            = 1'b0;
        hit             = 1'b0;
        stat            = STAT_MISS;
        prod            = '0;
        rem             = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep marks to empty, slot_reg serves as the address
                mark_we = 1'b1;
                if (slot_reg == LAST_SLOT)
                begin
                    slot_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next = slot_inc;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if ((cmd.opcode == OP_INSERT && live_reg >= HALF_CNT) ||
                        !(cmd.opcode == OP_INSERT || cmd.opcode == OP_LOOKUP ||
                          cmd.opcode == OP_REMOVE))
                    begin
                        // Answer at once: refused insert or unused opcode
                        emit = 1'b1;
                        stat = (cmd.opcode == OP_INSERT) ? STAT_FULL : STAT_MISS;
                    end
                    else if (CAP_POW2)
                    begin
                        slot_next  = key_m[IW-1:0];
                        state_next = ST_ISSUE;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                // Estimate key / CAPACITY by the truncated reciprocal, low by at most one
                prod       = (2*KEY_W)'(key_ext) * (2*KEY_W)'(RECIP);
                quot_next  = prod[2*KEY_W-1:KEY_W];
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // Form the remainder and fold it back once into range
                rem = key_ext - quot_reg * CAP_KEY;
                if (rem >= CAP_KEY)
                begin
                    rem = rem - CAP_KEY;
                end
                slot_next  = rem[IW-1:0];
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                rd_addr        = slot_reg;
                probe_cnt_next = '0;
                state_next     = ST_PROBE;
            end
            ST_PROBE:
            begin
                // Read the following slot ahead while this one is checked
                rd_addr = slot_inc;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (mark_rd_reg != MARK_USED)
                        begin
                            mark_we    = 1'b1;
                            mark_wdata = MARK_USED;
                            data_we    = 1'b1;
                            live_next  = CW'(live_reg + 1'b1);
                            emit       = 1'b1;
                            stat       = STAT_INSERTED;
                        end
                        else if (exhausted)
                        begin
                            emit = 1'b1;
                            stat = STAT_FULL;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (mark_rd_reg == MARK_EMPTY || (exhausted && !key_match))
                        begin
                            emit = 1'b1;
                            stat = STAT_MISS;
                        end
                        else if (key_match)
                        begin
                            emit = 1'b1;
                            hit  = 1'b1;
                            stat = STAT_HIT;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (mark_rd_reg == MARK_EMPTY || (exhausted && !key_match))
                        begin
                            emit = 1'b1;
                            stat = STAT_MISS;
                        end
                        else if (key_match)
                        begin
                            mark_we    = 1'b1;
                            mark_wdata = MARK_TOMB;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                            emit = 1'b1;
                            stat = STAT_REMOVED;
                        end
                    end
                    default:
                    begin
                        emit = 1'b1;
                        stat = STAT_MISS;
                    end
                endcase
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next      = slot_inc;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Form the response transfer
        done_next = emit;
        rsp_next  = rsp_reg;
        if (emit)
        begin
            rsp_next.status         = stat;
            rsp_next.found_value    = hit ? VALUE_W'(rd_val) : '0;
            rsp_next.entries_in_use = ENTRIES_W'(live_next);
        end
    end

    // Live count stays within half the capacity
    assert property (@(posedge clk) disable iff (!rst_n) live_reg <= HALF_CNT)
        else $error("live count above half capacity");

    // A strobe follows only a probe decision or an immediate answer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_PROBE || $past(state_reg) == ST_IDLE))
        else $error("done strobe from unexpected state");

    // A successful insert adds exactly one live entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_INSERTED) |-> (live_reg == CW'($past(live_reg) + 1'b1)))
        else $error("insert did not count one entry");

    // Stores are written only while a command or the sweep is in progress
    assert property (@(posedge clk) disable iff (!rst_n) (mark_we || data_we) |-> busy)
        else $error("memory write while idle");

    // No new command is taken while the mark sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("left mark sweep to a work state");

endmodule

`default_nettype wire
